@@ rtl/core/ccb_pkg.sv @@
package ccb_pkg;

  typedef enum logic [2:0] {
    CMD_ADDR        = 3'd0,
    CMD_DATA        = 3'd1,
    CMD_TICK        = 3'd2,
    CMD_INT_STATUS  = 3'd3,
    CMD_TUNE_STATUS = 3'd4,
    CMD_QUAL_STATUS = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_PINS      = 3'd0,
    KIND_REPLY     = 3'd1,
    KIND_BLEND     = 3'd2,
    KIND_TUNE      = 3'd3,
    KIND_INT_POLL  = 3'd4,
    KIND_TUNE_POLL = 3'd5,
    KIND_QUAL_POLL = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    REG_FORCE_MONO   = 3'd0,
    REG_AUTO_STEREO  = 3'd1,
    REG_IF_OFFSET    = 3'd2,
    REG_SETTLE_DELAY = 3'd3,
    REG_TUNE_PERIOD  = 3'd4,
    REG_SIGNAL_PERIOD = 3'd5,
    REG_PILOT_LEVEL  = 3'd6,
    REG_IF_COUNT     = 3'd7
  } reg_e;

  // Bus addresses and frame bytes
  localparam logic [7:0] ADDR_IF_COUNT = 8'h2A;
  localparam logic [7:0] ADDR_MODE     = 8'h29;
  localparam logic [7:0] ADDR_TUNE     = 8'h28;
  localparam logic [7:0] MODE_BYTE1    = 8'h00;
  localparam logic [7:0] MODE_BYTE2    = 8'h13;
  localparam logic [7:0] MODE_MONO     = 8'hAF;
  localparam logic [7:0] MODE_STEREO   = 8'hA7;
  localparam logic [7:0] TUNE_SET      = 8'h3B;
  localparam logic [7:0] TUNE_IF_STOP  = 8'h3F;

  // Register reset values
  localparam logic [6:0]  RST_FORCE_MONO    = 7'd127;
  localparam logic [6:0]  RST_AUTO_STEREO   = 7'd14;
  localparam logic [15:0] RST_IF_OFFSET     = 16'd10650;
  localparam logic [12:0] RST_IF_OFFSET_C10 = 13'd1065;  // ceil(10650 / 10)
  localparam logic [15:0] RST_SETTLE_DELAY  = 16'd1000;
  localparam logic [15:0] RST_TUNE_PERIOD   = 16'd10;
  localparam logic [15:0] RST_SIGNAL_PERIOD = 16'd300;
  localparam logic [7:0]  RST_PILOT_LEVEL   = 8'd128;
  localparam logic [23:0] RST_IF_COUNT      = 24'd8480344;

  // floor(x / 10) = (x * 0xCCCD) >> 19, exact for x below 81920
  localparam logic [15:0] RECIP_10    = 16'hCCCD;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [16:0] ROUND_UP_10 = 17'd9;

  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;
  } res_t;

  // All results caused by one item, with the pin levels after it
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [1:0]         cnt;
    logic               carrier;
    logic               stereo;
  } grp_t;

  typedef struct packed {
    logic [6:0]  force_mono;
    logic [6:0]  auto_stereo;
    logic [12:0] offset_c10;
    logic [15:0] settle_delay;
    logic [15:0] tune_period;
    logic [15:0] signal_period;
    logic [7:0]  pilot_level;
    logic [23:0] if_count;
  } cfg_t;

endpackage

@@ rtl/core/ccb_item_if.sv @@
interface ccb_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] byte_value;

  modport source (output valid, output cmd, output byte_value, input ready);
  modport sink   (input valid, input cmd, input byte_value, output ready);
endinterface

@@ rtl/core/ccb_result_if.sv @@
interface ccb_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] value;
  logic        carrier_pin;
  logic        stereo_pin;
  logic        last;

  modport source (output valid, output kind, output value, output carrier_pin,
                  output stereo_pin, output last, input ready);
  modport sink   (input valid, input kind, input value, input carrier_pin,
                  input stereo_pin, input last, output ready);
endinterface

@@ rtl/core/ccb_front.sv @@
module ccb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ccb_pkg::cfg_t     cfg_i,
  ccb_item_if.sink          item_i,
  input  logic              full_i,
  output logic              push_o,
  output ccb_pkg::grp_t     grp_o
);

  logic [7:0]  addr_q, addr_d;
  logic [7:0]  frame0_q, frame0_d, frame1_q, frame1_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        mono_q, mono_d;
  logic [15:0] freq_q, freq_d;
  logic        tuned_q, tuned_d;
  logic        detect_q, detect_d;
  logic [15:0] settle_q, settle_d;
  logic [15:0] tphase_q, tphase_d;
  logic [15:0] sphase_q, sphase_d;
  logic        carrier_q, carrier_d;
  logic        stereo_q, stereo_d;

  logic          accept;
  ccb_pkg::cmd_e cmd;
  logic [7:0]    b;
  logic [15:0]   freq_new;
  logic [18:0]   freq_x5;
  logic [18:0]   tune_word;
  logic [16:0]   tphase_inc, sphase_inc;
  logic          tune_due, signal_due;
  logic [15:0]   settle_inc;

  assign accept       = item_i.valid && item_i.ready;
  assign item_i.ready = !full_i;
  assign push_o       = accept;
  assign cmd          = ccb_pkg::cmd_e'(item_i.cmd);
  assign b            = item_i.byte_value;

  // (50f - off) / 10 floored equals 5f - ceil(off / 10); clamp below zero
  assign freq_new  = {frame1_q, frame0_q};
  assign freq_x5   = {1'b0, freq_new, 2'b00} + {3'b000, freq_new};
  assign tune_word = (freq_x5 >= {6'd0, cfg_i.offset_c10})
                     ? freq_x5 - {6'd0, cfg_i.offset_c10} : '0;

  assign tphase_inc = {1'b0, tphase_q} + 17'd1;
  assign sphase_inc = {1'b0, sphase_q} + 17'd1;
  assign tune_due   = tphase_inc >= {1'b0, cfg_i.tune_period};
  assign signal_due = sphase_inc >= {1'b0, cfg_i.signal_period};
  assign settle_inc = (settle_q == 16'hFFFF) ? settle_q : settle_q + 16'd1;

  always_comb begin
    logic [1:0] n;
    n         = '0;
    grp_o     = '0;
    addr_d    = addr_q;
    frame0_d  = frame0_q;
    frame1_d  = frame1_q;
    cnt_d     = cnt_q;
    mono_d    = mono_q;
    freq_d    = freq_q;
    tuned_d   = tuned_q;
    detect_d  = detect_q;
    settle_d  = settle_q;
    tphase_d  = tphase_q;
    sphase_d  = sphase_q;
    carrier_d = carrier_q;
    stereo_d  = stereo_q;

    unique case (cmd)
      ccb_pkg::CMD_ADDR: begin
        addr_d = b;
        cnt_d  = '0;
        if (b == ccb_pkg::ADDR_IF_COUNT) begin
          addr_d   = '0;
          stereo_d = 1'b0;
          grp_o.res[0] = '{ccb_pkg::KIND_REPLY, {8'd0, cfg_i.if_count[7:0]}};
          grp_o.res[1] = '{ccb_pkg::KIND_REPLY, {8'd0, cfg_i.if_count[15:8]}};
          grp_o.res[2] = '{ccb_pkg::KIND_REPLY, {8'd0, cfg_i.if_count[23:16]}};
          n = 2'd3;
        end
      end
      ccb_pkg::CMD_DATA: begin
        if (cnt_q != 2'd3) begin
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd0) begin
            frame0_d = b;
          end else if (cnt_q == 2'd1) begin
            frame1_d = b;
          end else begin
            // third byte completes the frame
            addr_d = '0;
            if (addr_q == ccb_pkg::ADDR_MODE && frame1_q == ccb_pkg::MODE_BYTE1 &&
                b == ccb_pkg::MODE_BYTE2) begin
              if (frame0_q == ccb_pkg::MODE_MONO && !mono_q) begin
                mono_d   = 1'b1;
                grp_o.res[n] = '{ccb_pkg::KIND_BLEND, {9'd0, cfg_i.force_mono}};
                n = n + 2'd1;
              end else if (frame0_q == ccb_pkg::MODE_STEREO && mono_q) begin
                mono_d   = 1'b0;
                grp_o.res[n] = '{ccb_pkg::KIND_BLEND, {9'd0, cfg_i.auto_stereo}};
                n = n + 2'd1;
              end
            end
            if (addr_q == ccb_pkg::ADDR_TUNE && b == ccb_pkg::TUNE_SET &&
                freq_new != freq_q) begin
              freq_d    = freq_new;
              carrier_d = 1'b0;
              stereo_d  = 1'b0;
              tuned_d   = 1'b0;
              detect_d  = 1'b0;
              settle_d  = '0;
              grp_o.res[n] = '{ccb_pkg::KIND_TUNE, tune_word[15:0]};
              n = n + 2'd1;
            end
            if (addr_q == ccb_pkg::ADDR_TUNE && b == ccb_pkg::TUNE_IF_STOP) begin
              stereo_d = 1'b1;
            end
          end
        end
      end
      ccb_pkg::CMD_TICK: begin
        tphase_d = tune_due ? '0 : tphase_inc[15:0];
        sphase_d = signal_due ? '0 : sphase_inc[15:0];
        settle_d = settle_inc;
        if (!tuned_q && tune_due) begin
          grp_o.res[n] = '{ccb_pkg::KIND_INT_POLL, 16'd0};
          n = n + 2'd1;
        end
        if (tuned_q && !detect_q && settle_inc > cfg_i.settle_delay) begin
          detect_d = 1'b1;
        end
        if (detect_d && signal_due) begin
          grp_o.res[n] = '{ccb_pkg::KIND_QUAL_POLL, 16'd0};
          n = n + 2'd1;
        end
      end
      ccb_pkg::CMD_INT_STATUS: begin
        if (!tuned_q && b[0]) begin
          tuned_d = 1'b1;
          grp_o.res[n] = '{ccb_pkg::KIND_TUNE_POLL, 16'd0};
          n = n + 2'd1;
        end
      end
      ccb_pkg::CMD_TUNE_STATUS: begin
        if (tuned_q && b[1:0] == 2'b01) begin
          carrier_d = 1'b1;
        end
      end
      ccb_pkg::CMD_QUAL_STATUS: begin
        if (detect_q) begin
          stereo_d = b > cfg_i.pilot_level;
        end
      end
      default: begin
      end
    endcase

    // an item with no request still reports the pins
    if (n == 2'd0) begin
      grp_o.res[0] = '{ccb_pkg::KIND_PINS, 16'd0};
      n = 2'd1;
    end
    grp_o.cnt     = n;
    grp_o.carrier = carrier_d;
    grp_o.stereo  = stereo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      frame0_q  <= '0;
      frame1_q  <= '0;
      cnt_q     <= '0;
      mono_q    <= 1'b0;
      freq_q    <= '0;
      tuned_q   <= 1'b1;
      detect_q  <= 1'b0;
      settle_q  <= '0;
      tphase_q  <= '0;
      sphase_q  <= '0;
      carrier_q <= 1'b0;
      stereo_q  <= 1'b0;
    end else if (accept) begin
      addr_q    <= addr_d;
      frame0_q  <= frame0_d;
      frame1_q  <= frame1_d;
      cnt_q     <= cnt_d;
      mono_q    <= mono_d;
      freq_q    <= freq_d;
      tuned_q   <= tuned_d;
      detect_q  <= detect_d;
      settle_q  <= settle_d;
      tphase_q  <= tphase_d;
      sphase_q  <= sphase_d;
      carrier_q <= carrier_d;
      stereo_q  <= stereo_d;
    end
  end

endmodule

@@ rtl/core/ccb_fifo.sv @@
module ccb_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ccb_pkg::grp_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output ccb_pkg::grp_t rdata_o,
  output logic          empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ccb_pkg::grp_t mem_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = cnt_q == FULL_CNT;
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("group pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("group popped from empty queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == FULL_CNT) |-> (wptr_q == rptr_q))
    else $error("queue pointers disagree with fill count");

endmodule

@@ rtl/core/ccb_back.sv @@
module ccb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  ccb_pkg::grp_t grp_i,
  output logic          pop_o,
  ccb_result_if.source  result_o
);

  ccb_pkg::grp_t grp_q;
  logic [1:0]    idx_q;
  logic          vld_q;
  logic          last;
  logic          take;

  assign last = (idx_q + 2'd1) == grp_q.cnt;
  assign take = vld_q && result_o.ready;
  // load the next group when nothing is held or the held one just finished
  assign pop_o = !empty_i && (!vld_q || (take && last));

  assign result_o.valid       = vld_q;
  assign result_o.kind        = grp_q.res[idx_q].kind;
  assign result_o.value       = grp_q.res[idx_q].value;
  assign result_o.carrier_pin = grp_q.carrier;
  assign result_o.stereo_pin  = grp_q.stereo;
  assign result_o.last        = last;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      grp_q <= grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (take) begin
      if (last) begin
        vld_q <= 1'b0;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (idx_q < grp_q.cnt))
    else $error("result index beyond its group");

endmodule

@@ rtl/core/ccb_to_fm_tuner_bridge.sv @@
// Bridge from a host's serial command bus to an FM tuner. Each item on item_i is a
// bus address byte, a bus data byte, a tick, or one of three tuner status bytes.
// The front end takes one item per cycle while the queue has room, updates the
// frame, mode, frequency, settle and poll state at once, and turns the item into a
// group of one to three results (bus reply bytes, blend, tune and poll requests,
// or a bare pin update). Groups wait in a queue of QUEUE_DEPTH entries; the back
// end plays each group out on result_o one result per cycle while result_o.ready
// is high, carrying the carrier and stereo pin levels that held after its item and
// flagging the final result with last. Sustained rate is one item per cycle while
// each item yields one result and result_o is ready; only a full queue stalls
// item_i. A result passes the queue entry and the back end's grp_q. Registers
// sit on the APB port at byte address 4*i and take effect for the next item.
module ccb_to_fm_tuner_bridge #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ccb_item_if.sink     item_i,
  ccb_result_if.source result_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  ccb_pkg::cfg_t cfg_q;
  logic [15:0]   if_offset_q;
  logic          cfg_we;
  ccb_pkg::reg_e reg_idx;
  logic [16:0]   offset_rnd;
  logic [32:0]   offset_prod;

  logic          push, pop, full, empty;
  ccb_pkg::grp_t push_grp, pop_grp;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = ccb_pkg::reg_e'(paddr[4:2]);

  // Keep ceil(if_offset / 10) ready so the tune word needs only a subtract
  assign offset_rnd  = {1'b0, pwdata[15:0]} + ccb_pkg::ROUND_UP_10;
  assign offset_prod = offset_rnd * ccb_pkg::RECIP_10;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.force_mono    <= ccb_pkg::RST_FORCE_MONO;
      cfg_q.auto_stereo   <= ccb_pkg::RST_AUTO_STEREO;
      cfg_q.offset_c10    <= ccb_pkg::RST_IF_OFFSET_C10;
      cfg_q.settle_delay  <= ccb_pkg::RST_SETTLE_DELAY;
      cfg_q.tune_period   <= ccb_pkg::RST_TUNE_PERIOD;
      cfg_q.signal_period <= ccb_pkg::RST_SIGNAL_PERIOD;
      cfg_q.pilot_level   <= ccb_pkg::RST_PILOT_LEVEL;
      cfg_q.if_count      <= ccb_pkg::RST_IF_COUNT;
      if_offset_q         <= ccb_pkg::RST_IF_OFFSET;
    end else if (cfg_we) begin
      unique case (reg_idx)
        ccb_pkg::REG_FORCE_MONO:    cfg_q.force_mono    <= pwdata[6:0];
        ccb_pkg::REG_AUTO_STEREO:   cfg_q.auto_stereo   <= pwdata[6:0];
        ccb_pkg::REG_IF_OFFSET: begin
          if_offset_q      <= pwdata[15:0];
          cfg_q.offset_c10 <= offset_prod[ccb_pkg::RECIP_SHIFT +: 13];
        end
        ccb_pkg::REG_SETTLE_DELAY:  cfg_q.settle_delay  <= pwdata[15:0];
        ccb_pkg::REG_TUNE_PERIOD:   cfg_q.tune_period   <= pwdata[15:0];
        ccb_pkg::REG_SIGNAL_PERIOD: cfg_q.signal_period <= pwdata[15:0];
        ccb_pkg::REG_PILOT_LEVEL:   cfg_q.pilot_level   <= pwdata[7:0];
        ccb_pkg::REG_IF_COUNT:      cfg_q.if_count      <= pwdata[23:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ccb_pkg::REG_FORCE_MONO:    prdata = {25'd0, cfg_q.force_mono};
      ccb_pkg::REG_AUTO_STEREO:   prdata = {25'd0, cfg_q.auto_stereo};
      ccb_pkg::REG_IF_OFFSET:     prdata = {16'd0, if_offset_q};
      ccb_pkg::REG_SETTLE_DELAY:  prdata = {16'd0, cfg_q.settle_delay};
      ccb_pkg::REG_TUNE_PERIOD:   prdata = {16'd0, cfg_q.tune_period};
      ccb_pkg::REG_SIGNAL_PERIOD: prdata = {16'd0, cfg_q.signal_period};
      ccb_pkg::REG_PILOT_LEVEL:   prdata = {24'd0, cfg_q.pilot_level};
      ccb_pkg::REG_IF_COUNT:      prdata = {8'd0, cfg_q.if_count};
      default:                    prdata = '0;
    endcase
  end

  // Front: decode the item and update state; stall only on a full queue
  ccb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .item_i (item_i),
    .full_i (full),
    .push_o (push),
    .grp_o  (push_grp)
  );

  // Queue of result groups between front and back
  ccb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_grp),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_grp),
    .empty_o (empty)
  );

  // Back: serialize each group onto the result channel
  ccb_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .grp_i    (pop_grp),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule
